### hdl/psch_pkg.sv
// Package for the preemptive priority scheduler: beat structs, phase codes,
// command codes and scan control. No dependencies.
package psch_pkg;

  localparam int PHASE_W = 3;
  localparam int REM_W   = 16;  // burst/remaining counter width

  localparam logic [PHASE_W-1:0] PH_EMPTY = 3'd0;
  localparam logic [PHASE_W-1:0] PH_NEW   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_READY = 3'd2;
  localparam logic [PHASE_W-1:0] PH_RUN   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_DONE  = 3'd4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [3:0]  slot;
    logic [7:0]  priority_req;
    logic [15:0] arrival_time;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic [15:0] tick_time;
    logic        running_valid;
    logic [3:0]  running_slot;
    logic        finished;
    logic [15:0] turnaround;
    logic [15:0] switch_total;
  } out_item_t;

  typedef struct packed {
    logic clear;    // start of a tick: forget the previous best
    logic en;       // an entry is on the read port
    logic cur_hit;  // that entry is the running task
  } scan_ctl_t;

endpackage

### hdl/psch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module psch_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/psch_scan.sv
// Scan unit: admission compare and best-ready tracking, one slot per cycle.
// Depends on psch_pkg.
module psch_scan #(
  parameter int TASK_SLOTS    = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TIME_BITS     = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  psch_pkg::scan_ctl_t           ctl,
  input  logic [$clog2(TASK_SLOTS)-1:0] idx,
  input  logic [psch_pkg::PHASE_W-1:0]  phase_in,
  input  logic [PRIORITY_BITS-1:0]      prio_in,
  input  logic [TIME_BITS-1:0]          arr_in,
  input  logic [TIME_BITS-1:0]          now_in,
  output logic                          admit,
  output logic                          best_valid,
  output logic [$clog2(TASK_SLOTS)-1:0] best_idx,
  output logic [PRIORITY_BITS-1:0]      best_prio,
  output logic [PRIORITY_BITS-1:0]      cur_prio
);
  import psch_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);

  logic                     best_valid_r;
  logic [SLOT_W-1:0]        best_idx_r;
  logic [PRIORITY_BITS-1:0] best_prio_r;
  logic [PRIORITY_BITS-1:0] cur_prio_r;
  logic                     rdy;
  logic                     take;

  always_comb begin
    admit = ctl.en && (phase_in == PH_NEW) && (arr_in <= now_in);
    rdy   = ctl.en && ((phase_in == PH_READY) || admit);
    // strict greater keeps the lowest slot on ties
    take  = rdy && (!best_valid_r || (prio_in > best_prio_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (ctl.clear) begin
      best_valid_r <= 1'b0;
    end else if (take) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r  <= idx;
      best_prio_r <= prio_in;
    end
    if (ctl.en && ctl.cur_hit) begin
      cur_prio_r <= prio_in;
    end
  end

  assign best_valid = best_valid_r;
  assign best_idx   = best_idx_r;
  assign best_prio  = best_prio_r;
  assign cur_prio   = cur_prio_r;

endmodule

### hdl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler top level: sequencer, slot phases, task RAM.
// Depends on psch_pkg, psch_ram, psch_scan.
//
// Usage: drive in_item and raise start; the beat is taken at a clock edge
// with start high and busy low. A load beat (mode 0) writes one task slot in
// that same cycle and leaves busy low, so loads may follow back to back.
// A tick beat (mode 1) raises busy and steps through its states: S_SCAN
// reads the task RAM one slot per cycle and updates arrivals and the best
// ready candidate, S_DRAIN drains the RAM read stage, S_PICK picks/preempts
// and reads the running task, and S_EXEC decrements and retires it.
// The result of a tick appears on out_item with out_valid high for exactly
// one cycle, in the cycle busy falls; load beats give no result.
// The receiver cannot stall, so results are never held.
// Reset (rst_n low, synchronous) empties all slots, clears time, the running
// task and the switch count; no clearing pass is needed since task RAM data
// is only used for slots whose phase is not empty.
module preemptive_priority_scheduler #(
  parameter int TASK_SLOTS    = 16,
  parameter int PRIORITY_BITS = 8,
  parameter int TIME_BITS     = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  psch_pkg::in_item_t  in_item,
  output logic                out_valid,
  output psch_pkg::out_item_t out_item
);
  import psch_pkg::*;

  localparam int SLOT_W = $clog2(TASK_SLOTS);
  localparam int WORD_W = PRIORITY_BITS + TIME_BITS + REM_W;
  localparam int TW1    = TIME_BITS + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PICK  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [SLOT_W-1:0]      cnt_r, cnt_nxt;
  logic                   proc_v_r;
  logic [SLOT_W-1:0]      proc_idx_r;
  logic [PHASE_W-1:0]     phase_r [TASK_SLOTS];
  logic [PHASE_W-1:0]     phase_nxt [TASK_SLOTS];
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic [SLOT_W-1:0]      cur_slot_r, cur_slot_nxt;
  logic                   cur_valid_r, cur_valid_nxt;
  logic [15:0]            sw_r, sw_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  // RAM port signals
  logic                   we;
  logic [SLOT_W-1:0]      waddr, raddr;
  logic [WORD_W-1:0]      wdata, rdata;

  // scan unit
  scan_ctl_t              sctl;
  logic                   admit, best_valid;
  logic [SLOT_W-1:0]      best_idx;
  logic [PRIORITY_BITS-1:0] best_prio, cur_prio;

  logic                   accept, ld, slot_ok;
  logic [SLOT_W-1:0]      ld_slot;
  logic                   preempt, dispatch;
  logic [SLOT_W-1:0]      run_slot;
  logic [REM_W-1:0]       rem_cur, rem_dec;
  logic [TIME_BITS-1:0]   arr_cur;
  logic [TW1-1:0]         done_t, ta_raw;
  logic [32:0]            ta_wide;
  logic                   fin;

  psch_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TASK_SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  psch_scan #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (sctl),
    .idx        (proc_idx_r),
    .phase_in   (phase_r[proc_idx_r]),
    .prio_in    (rdata[WORD_W-1 -: PRIORITY_BITS]),
    .arr_in     (rdata[REM_W +: TIME_BITS]),
    .now_in     (now_r),
    .admit      (admit),
    .best_valid (best_valid),
    .best_idx   (best_idx),
    .best_prio  (best_prio),
    .cur_prio   (cur_prio)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    slot_ok  = (32'(in_item.slot) < TASK_SLOTS);
    ld_slot  = SLOT_W'(in_item.slot);
    ld       = accept && (in_item.mode == MODE_LOAD) && slot_ok;

    preempt  = cur_valid_r && best_valid && (best_prio > cur_prio);
    dispatch = !cur_valid_r && best_valid;
    run_slot = (preempt || dispatch) ? best_idx : cur_slot_r;

    rem_cur  = rdata[REM_W-1:0];
    arr_cur  = rdata[REM_W +: TIME_BITS];
    rem_dec  = (rem_cur != '0) ? rem_cur - REM_W'(1) : rem_cur;
    fin      = cur_valid_r && (rem_dec == '0);
    done_t   = TW1'(now_r) + TW1'(1);
    ta_raw   = (done_t >= TW1'(arr_cur)) ? done_t - TW1'(arr_cur) : '0;
    ta_wide  = 33'(ta_raw);

    sctl.clear   = accept && (in_item.mode == MODE_TICK);
    sctl.en      = proc_v_r;
    sctl.cur_hit = cur_valid_r && (proc_idx_r == cur_slot_r);

    raddr = (state_r == S_PICK) ? run_slot : cnt_r;
    we    = 1'b0;
    waddr = ld_slot;
    wdata = {PRIORITY_BITS'(in_item.priority_req), TIME_BITS'(in_item.arrival_time),
             in_item.burst_length};

    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    now_nxt       = now_r;
    cur_slot_nxt  = cur_slot_r;
    cur_valid_nxt = cur_valid_r;
    sw_nxt        = sw_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    if (admit) begin
      phase_nxt[proc_idx_r] = PH_READY;
    end

    unique case (state_r)
      S_IDLE: begin
        if (ld) begin
          if (cur_valid_r && (cur_slot_r == ld_slot)) begin
            cur_valid_nxt = 1'b0;
          end
          if (in_item.burst_length == '0) begin
            phase_nxt[ld_slot] = PH_EMPTY;
          end else begin
            we                 = 1'b1;
            phase_nxt[ld_slot] = PH_NEW;
          end
        end else if (accept && (in_item.mode == MODE_TICK)) begin
          cnt_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == SLOT_W'(TASK_SLOTS - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + SLOT_W'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_PICK;
      end
      S_PICK: begin
        if (preempt) begin
          phase_nxt[cur_slot_r] = PH_READY;
          phase_nxt[best_idx]   = PH_RUN;
          cur_slot_nxt          = best_idx;
        end else if (dispatch) begin
          phase_nxt[best_idx] = PH_RUN;
          cur_slot_nxt        = best_idx;
          cur_valid_nxt       = 1'b1;
        end
        if ((preempt || dispatch) && (sw_r != 16'hFFFF)) begin
          sw_nxt = sw_r + 16'd1;
        end
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        // rdata holds the running task read in the pick cycle
        if (cur_valid_r) begin
          we    = 1'b1;
          waddr = cur_slot_r;
          wdata = {rdata[WORD_W-1 -: PRIORITY_BITS], arr_cur, rem_dec};
        end
        if (fin) begin
          phase_nxt[cur_slot_r] = PH_DONE;
          cur_valid_nxt         = 1'b0;
        end
        out_nxt.tick_time     = 16'(now_r);
        out_nxt.running_valid = cur_valid_r;
        out_nxt.running_slot  = cur_valid_r ? 4'(cur_slot_r) : 4'd0;
        out_nxt.finished      = fin;
        out_nxt.turnaround    = !fin ? 16'd0 :
                                (ta_wide > 33'd65535) ? 16'hFFFF : 16'(ta_raw);
        out_nxt.switch_total  = sw_r;
        out_valid_nxt         = 1'b1;
        now_nxt               = now_r + TIME_BITS'(1);
        state_nxt             = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      proc_v_r    <= 1'b0;
      phase_r     <= '{default: PH_EMPTY};
      now_r       <= '0;
      cur_slot_r  <= '0;
      cur_valid_r <= 1'b0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      proc_v_r    <= (state_r == S_SCAN);
      phase_r     <= phase_nxt;
      now_r       <= now_nxt;
      cur_slot_r  <= cur_slot_nxt;
      cur_valid_r <= cur_valid_nxt;
      sw_r        <= sw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    proc_idx_r <= cnt_r;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  // a tick ends exactly when its result is shown
  a_busy_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid_r)
    else $error("busy fell without a result");

  // the running task is always marked as running in the phase table
  a_cur_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (phase_r[cur_slot_r] == PH_RUN))
    else $error("running slot not in run phase");

  a_fin_running: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.finished) |-> out_r.running_valid)
    else $error("finish reported on an idle tick");

endmodule
